// File: rtl/core/tapc_pkg.sv
// tapc_pkg: shared types and constants of the three-axis PI position controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package tapc_pkg;

    localparam int AXES = 3;

    // opcodes of an input beat
    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_POSE  = 3'd1;
    localparam logic [2:0] OP_CTRL  = 3'd2;
    localparam logic [2:0] OP_OVR   = 3'd3;
    localparam logic [2:0] OP_TICK  = 3'd4;

    // arrival radius, Q15.16 metres, and its square in Q32
    localparam logic [31:0] ARRIVE_RADIUS_Q16 = 32'd13107;
    localparam logic [63:0] ARRIVE_DIST_SQ =
        {32'b0, ARRIVE_RADIUS_Q16} * {32'b0, ARRIVE_RADIUS_Q16};

    typedef logic signed [31:0] pos_t;
    typedef logic signed [32:0] err_t;
    typedef logic signed [47:0] integ_t;

    typedef struct packed {
        pos_t        target_x;
        pos_t        target_y;
        pos_t        target_z;
        logic        station_keeping;
        logic [15:0] prop_gain;
        logic [15:0] int_gain;
        logic [30:0] speed_limit;
        logic [31:0] stall_ticks;
    } cfg_t;

    // classified beat handed from the front to the back
    typedef struct packed {
        logic [2:0]            opcode;
        logic                  start_enable;
        logic                  user_override;
        err_t [AXES-1:0]       err;
        logic [63:0]           dist_sq;
    } item_t;

endpackage

`default_nettype wire

// File: rtl/core/tapc_regs.sv
// tapc_regs: APB configuration registers (targets, gains, limits, stall period).
// Depends on tapc_pkg.
`default_nettype none

module tapc_regs (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [4:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output tapc_pkg::cfg_t      cfg
);
    import tapc_pkg::*;

    localparam logic [2:0] REG_TARGET_X    = 3'd0;
    localparam logic [2:0] REG_TARGET_Y    = 3'd1;
    localparam logic [2:0] REG_TARGET_Z    = 3'd2;
    localparam logic [2:0] REG_STATION     = 3'd3;
    localparam logic [2:0] REG_PROP_GAIN   = 3'd4;
    localparam logic [2:0] REG_INT_GAIN    = 3'd5;
    localparam logic [2:0] REG_SPEED_LIMIT = 3'd6;
    localparam logic [2:0] REG_STALL_TICKS = 3'd7;

    cfg_t       cfg_reg;
    logic [2:0] idx;
    logic       wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_x        <= '0;
            cfg_reg.target_y        <= '0;
            cfg_reg.target_z        <= '0;
            cfg_reg.station_keeping <= 1'b0;
            cfg_reg.prop_gain       <= 16'd2048;
            cfg_reg.int_gain        <= 16'd0;
            cfg_reg.speed_limit     <= 31'd327680;
            cfg_reg.stall_ticks     <= 32'd5000;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_TARGET_X:    cfg_reg.target_x        <= pwdata;
                REG_TARGET_Y:    cfg_reg.target_y        <= pwdata;
                REG_TARGET_Z:    cfg_reg.target_z        <= pwdata;
                REG_STATION:     cfg_reg.station_keeping <= pwdata[0];
                REG_PROP_GAIN:   cfg_reg.prop_gain       <= pwdata[15:0];
                REG_INT_GAIN:    cfg_reg.int_gain        <= pwdata[15:0];
                REG_SPEED_LIMIT: cfg_reg.speed_limit     <= pwdata[30:0];
                REG_STALL_TICKS: cfg_reg.stall_ticks     <= pwdata;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_TARGET_X:    prdata = cfg_reg.target_x;
            REG_TARGET_Y:    prdata = cfg_reg.target_y;
            REG_TARGET_Z:    prdata = cfg_reg.target_z;
            REG_STATION:     prdata = {31'b0, cfg_reg.station_keeping};
            REG_PROP_GAIN:   prdata = {16'b0, cfg_reg.prop_gain};
            REG_INT_GAIN:    prdata = {16'b0, cfg_reg.int_gain};
            REG_SPEED_LIMIT: prdata = {1'b0, cfg_reg.speed_limit};
            REG_STALL_TICKS: prdata = cfg_reg.stall_ticks;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/tapc_front.sv
// tapc_front: accepts input beats and classifies them in three stages:
// axis error, squared magnitudes, saturated squared distance. Depends on tapc_pkg.
`default_nettype none

module tapc_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire tapc_pkg::cfg_t cfg,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [2:0]     opcode,
    input  wire logic           start_enable,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] pos_z,
    input  wire logic           user_override,
    output logic                q_push,
    output tapc_pkg::item_t     q_item,
    input  wire logic           q_ready
);
    import tapc_pkg::*;

    logic        adv;
    logic        accept;

    logic        s1_valid_reg;
    logic [2:0]  s1_op_reg;
    logic        s1_se_reg;
    logic        s1_uo_reg;
    err_t        s1_err_reg [AXES];

    logic        s2_valid_reg;
    logic [2:0]  s2_op_reg;
    logic        s2_se_reg;
    logic        s2_uo_reg;
    err_t        s2_err_reg [AXES];
    logic [63:0] s2_sq_reg  [AXES];

    logic        s3_valid_reg;
    item_t       s3_item_reg;

    err_t        err_in   [AXES];
    logic [63:0] sq_next  [AXES];
    logic [65:0] sum_full;
    logic [63:0] dist_next;

    // whole front stalls together when the last stage cannot enter the queue
    assign adv      = !s3_valid_reg || q_ready;
    assign in_ready = adv;
    assign accept   = in_valid && adv;
    assign q_push   = s3_valid_reg && q_ready;
    assign q_item   = s3_item_reg;

    assign err_in[0] = $signed({cfg.target_x[31], cfg.target_x}) - $signed({pos_x[31], pos_x});
    assign err_in[1] = $signed({cfg.target_y[31], cfg.target_y}) - $signed({pos_y[31], pos_y});
    assign err_in[2] = $signed({cfg.target_z[31], cfg.target_z}) - $signed({pos_z[31], pos_z});

    // |err| never exceeds 2^32-1, so the magnitude fits 32 bits
    always_comb
    begin
        for (int k = 0; k < AXES; k++)
        begin
            logic [32:0] neg;
            logic [31:0] mag;
            neg = -s1_err_reg[k];
            mag = s1_err_reg[k][32] ? neg[31:0] : s1_err_reg[k][31:0];
            sq_next[k] = mag * mag;
        end
    end

    assign sum_full  = {2'b0, s2_sq_reg[0]} + {2'b0, s2_sq_reg[1]} + {2'b0, s2_sq_reg[2]};
    assign dist_next = (sum_full[65:64] != 2'b00) ? '1 : sum_full[63:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_op_reg <= opcode;
            s1_se_reg <= start_enable;
            s1_uo_reg <= user_override;
            s2_op_reg <= s1_op_reg;
            s2_se_reg <= s1_se_reg;
            s2_uo_reg <= s1_uo_reg;
            for (int k = 0; k < AXES; k++)
            begin
                s1_err_reg[k]         <= err_in[k];
                s2_err_reg[k]         <= s1_err_reg[k];
                s2_sq_reg[k]          <= sq_next[k];
                s3_item_reg.err[k]    <= s2_err_reg[k];
            end
            s3_item_reg.opcode        <= s2_op_reg;
            s3_item_reg.start_enable  <= s2_se_reg;
            s3_item_reg.user_override <= s2_uo_reg;
            s3_item_reg.dist_sq       <= dist_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/tapc_queue.sv
// tapc_queue: short FIFO of classified beats between front and back.
// Depends on tapc_pkg.
`default_nettype none

module tapc_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire tapc_pkg::item_t push_item,
    output logic                 not_full,
    output logic                 valid,
    output tapc_pkg::item_t      head,
    input  wire logic            pop
);
    import tapc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign not_full = count_reg != CNT_W'(DEPTH);
    assign valid    = count_reg != '0;
    assign head     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

// File: rtl/core/tapc_back.sv
// tapc_back: executes classified beats against the mission state, then computes
// the PI command in three stages (products, sum/scale, clamp). Depends on tapc_pkg.
`default_nettype none

module tapc_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire tapc_pkg::cfg_t  cfg,
    input  wire logic            q_valid,
    input  wire tapc_pkg::item_t q_item,
    output logic                 q_pop,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic                 cmd_valid,
    output logic signed [31:0]   vel_x,
    output logic signed [31:0]   vel_y,
    output logic signed [31:0]   vel_z,
    output logic                 executing,
    output logic                 at_target,
    output logic                 mission_done,
    output logic                 mission_ok
);
    import tapc_pkg::*;

    typedef struct packed {
        logic cmd;
        logic pi;
        logic done;
        logic ok;
        logic exec;
        logic reached;
    } flags_t;

    localparam integ_t INTEG_MAX = {1'b0, {47{1'b1}}};
    localparam integ_t INTEG_MIN = {1'b1, {47{1'b0}}};
    localparam logic signed [63:0] ITERM_LIM = 64'sh1000_0000_0000_0000;
    localparam logic signed [63:0] ITERM_NEG = -ITERM_LIM;

    function automatic logic signed [31:0] clamp_vel(
        input logic signed [51:0] v,
        input logic [30:0]        lim
    );
        logic signed [51:0] hi;
        logic signed [51:0] lo;
        logic signed [31:0] r;
        hi = $signed({21'b0, lim});
        lo = -hi;
        if (v > hi)
            r = $signed({1'b0, lim});
        else if (v < lo)
            r = -$signed({1'b0, lim});
        else
            r = v[31:0];
        return r;
    endfunction

    // mission state
    logic        exec_reg, exec_next;
    logic        reached_reg, reached_next;
    logic        loop_reg, loop_next;
    logic        ovr_reg, ovr_next;
    err_t        axis_err_reg [AXES];
    err_t        axis_err_next [AXES];
    integ_t      integ_reg [AXES];
    integ_t      integ_next [AXES];
    integ_t      integ_sat [AXES];
    logic [63:0] last_dist_reg, last_dist_next;
    logic [31:0] tick_reg, tick_next;

    logic        b_adv;
    logic        near;
    logic        stall_due;
    flags_t      e_flags_next;

    // pipeline stages
    logic        e_valid_reg;
    flags_t      e_flags_reg;
    err_t        e_err_reg [AXES];
    integ_t      e_integ_reg [AXES];

    logic               m_valid_reg;
    flags_t             m_flags_reg;
    logic signed [49:0] m_p_reg [AXES];
    logic signed [63:0] m_i_reg [AXES];
    logic signed [49:0] m_p_next [AXES];
    logic signed [63:0] m_i_next [AXES];

    logic               a_valid_reg;
    flags_t             a_flags_reg;
    logic signed [50:0] a_term_reg [AXES];
    logic signed [50:0] a_term_next [AXES];

    logic               o_valid_reg;
    logic               o_cmd_reg;
    logic signed [31:0] o_vel_x_reg, o_vel_y_reg, o_vel_z_reg;
    logic               o_exec_reg, o_reached_reg, o_done_reg, o_ok_reg;
    logic signed [31:0] vx_next, vy_next, vz_next;

    // back pipeline stalls as a whole while the output register is held
    assign b_adv = !o_valid_reg || out_ready;
    assign q_pop = q_valid && b_adv;

    assign near      = q_item.dist_sq < ARRIVE_DIST_SQ;
    assign stall_due = tick_reg > cfg.stall_ticks;

    always_comb
    begin
        for (int k = 0; k < AXES; k++)
        begin
            logic signed [48:0] s;
            s = $signed({integ_reg[k][47], integ_reg[k]})
              + $signed({{16{axis_err_reg[k][32]}}, axis_err_reg[k]});
            if (s[48] != s[47])
                integ_sat[k] = s[48] ? INTEG_MIN : INTEG_MAX;
            else
                integ_sat[k] = s[47:0];
        end
    end

    always_comb
    begin
        exec_next      = exec_reg;
        reached_next   = reached_reg;
        loop_next      = loop_reg;
        ovr_next       = ovr_reg;
        axis_err_next  = axis_err_reg;
        integ_next     = integ_reg;
        last_dist_next = last_dist_reg;
        tick_next      = tick_reg;
        e_flags_next   = '0;
        if (q_pop)
        begin
            unique case (q_item.opcode)
                OP_START:
                begin
                    reached_next   = 1'b0;
                    last_dist_next = '1;
                    tick_next      = '0;
                    for (int k = 0; k < AXES; k++)
                        integ_next[k] = '0;
                    exec_next = q_item.start_enable;
                    loop_next = q_item.start_enable;
                    if (!q_item.start_enable)
                    begin
                        e_flags_next.cmd  = 1'b1;
                        e_flags_next.done = 1'b1;
                    end
                end
                OP_POSE:
                begin
                    for (int k = 0; k < AXES; k++)
                        axis_err_next[k] = q_item.err[k];
                    if (!cfg.station_keeping && exec_reg && near)
                        reached_next = 1'b1;
                    if (stall_due)
                    begin
                        tick_next = '0;
                        if (!cfg.station_keeping && exec_reg && !ovr_reg
                            && (q_item.dist_sq >= last_dist_reg))
                            exec_next = 1'b0;
                        last_dist_next = q_item.dist_sq;
                    end
                end
                OP_CTRL:
                begin
                    if (loop_reg)
                    begin
                        if (!exec_reg || reached_reg)
                        begin
                            loop_next         = 1'b0;
                            e_flags_next.cmd  = 1'b1;
                            e_flags_next.done = 1'b1;
                            e_flags_next.ok   = exec_reg && reached_reg;
                        end
                        else if (!ovr_reg)
                        begin
                            integ_next      = integ_sat;
                            e_flags_next.cmd = 1'b1;
                            e_flags_next.pi  = 1'b1;
                        end
                    end
                end
                OP_OVR:
                    ovr_next = q_item.user_override;
                OP_TICK:
                begin
                    if (tick_reg != '1)
                        tick_next = tick_reg + 1'b1;
                end
                default:
                    ;
            endcase
        end
        e_flags_next.exec    = exec_next;
        e_flags_next.reached = reached_next;
    end

    // products: 17x33 and 17x48
    always_comb
    begin
        for (int k = 0; k < AXES; k++)
        begin
            logic signed [64:0] i_full;
            m_p_next[k] = $signed({1'b0, cfg.prop_gain}) * e_err_reg[k];
            i_full      = $signed({1'b0, cfg.int_gain}) * e_integ_reg[k];
            m_i_next[k] = i_full[63:0];
        end
    end

    // integral clamp, sum, floor divide by 4096
    always_comb
    begin
        for (int k = 0; k < AXES; k++)
        begin
            logic signed [63:0] isat;
            logic signed [62:0] s;
            if (m_i_reg[k] > ITERM_LIM)
                isat = ITERM_LIM;
            else if (m_i_reg[k] < ITERM_NEG)
                isat = ITERM_NEG;
            else
                isat = m_i_reg[k];
            s = 63'(m_p_reg[k]) + isat[62:0];
            a_term_next[k] = s[62:12];
        end
    end

    // axes swap: x from y, y from negated x
    always_comb
    begin
        logic signed [51:0] neg_x;
        neg_x   = -$signed({a_term_reg[0][50], a_term_reg[0]});
        vx_next = clamp_vel($signed({a_term_reg[1][50], a_term_reg[1]}), cfg.speed_limit);
        vy_next = clamp_vel(neg_x, cfg.speed_limit);
        vz_next = clamp_vel($signed({a_term_reg[2][50], a_term_reg[2]}), cfg.speed_limit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exec_reg      <= 1'b0;
            reached_reg   <= 1'b0;
            loop_reg      <= 1'b0;
            ovr_reg       <= 1'b0;
            last_dist_reg <= '1;
            tick_reg      <= '0;
            for (int k = 0; k < AXES; k++)
            begin
                axis_err_reg[k] <= '0;
                integ_reg[k]    <= '0;
            end
            e_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            exec_reg      <= exec_next;
            reached_reg   <= reached_next;
            loop_reg      <= loop_next;
            ovr_reg       <= ovr_next;
            last_dist_reg <= last_dist_next;
            tick_reg      <= tick_next;
            axis_err_reg  <= axis_err_next;
            integ_reg     <= integ_next;
            if (b_adv)
            begin
                e_valid_reg <= q_pop;
                m_valid_reg <= e_valid_reg;
                a_valid_reg <= m_valid_reg;
                o_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_adv)
        begin
            e_flags_reg <= e_flags_next;
            m_flags_reg <= e_flags_reg;
            a_flags_reg <= m_flags_reg;
            for (int k = 0; k < AXES; k++)
            begin
                e_err_reg[k]   <= axis_err_reg[k];
                e_integ_reg[k] <= integ_next[k];
                m_p_reg[k]     <= m_p_next[k];
                m_i_reg[k]     <= m_i_next[k];
                a_term_reg[k]  <= a_term_next[k];
            end
            o_cmd_reg     <= a_flags_reg.cmd;
            o_vel_x_reg   <= a_flags_reg.pi ? vx_next : '0;
            o_vel_y_reg   <= a_flags_reg.pi ? vy_next : '0;
            o_vel_z_reg   <= a_flags_reg.pi ? vz_next : '0;
            o_exec_reg    <= a_flags_reg.exec;
            o_reached_reg <= a_flags_reg.reached;
            o_done_reg    <= a_flags_reg.done;
            o_ok_reg      <= a_flags_reg.ok;
        end
    end

    assign out_valid    = o_valid_reg;
    assign cmd_valid    = o_cmd_reg;
    assign vel_x        = o_vel_x_reg;
    assign vel_y        = o_vel_y_reg;
    assign vel_z        = o_vel_z_reg;
    assign executing    = o_exec_reg;
    assign at_target    = o_reached_reg;
    assign mission_done = o_done_reg;
    assign mission_ok   = o_ok_reg;

    a_idle_vel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && !o_cmd_reg |-> o_vel_x_reg == '0 && o_vel_y_reg == '0
                                      && o_vel_z_reg == '0)
        else $error("velocity nonzero on a beat without command");

    a_ok_implies_done: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && o_ok_reg |-> o_done_reg && o_exec_reg && o_reached_reg)
        else $error("mission_ok without a successful end");

    a_reach_from_pose: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(reached_reg) |-> $past(q_pop && q_item.opcode == OP_POSE))
        else $error("arrival flag set by something other than a pose sample");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        $past(q_pop && q_item.opcode == OP_START) |->
            integ_reg[0] == '0 && integ_reg[1] == '0 && integ_reg[2] == '0
            && tick_reg == '0 && last_dist_reg == '1 && !reached_reg)
        else $error("start did not clear integrators and stall watch");

endmodule

`default_nettype wire

// File: rtl/core/three_axis_pi_position_controller_top.sv
// An accepted input beat passes through 3 front stages, one queue slot, then the
// execute, product and scale stages and the output register to its result beat.
// Throughput: one beat per cycle unless stalled; mission state updates on each beat.
// An output stall holds the back pipeline and fills the QUEUE_DEPTH-entry queue.
// Reset: rst_n (async, active low) clears mission state and loads register defaults.
// Depends on tapc_pkg, tapc_regs, tapc_front, tapc_queue, tapc_back.
`default_nettype none

module three_axis_pi_position_controller_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         opcode,
    input  wire logic               start_enable,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] pos_z,
    input  wire logic               user_override,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    cmd_valid,
    output logic signed [31:0]      vel_x,
    output logic signed [31:0]      vel_y,
    output logic signed [31:0]      vel_z,
    output logic                    executing,
    output logic                    at_target,
    output logic                    mission_done,
    output logic                    mission_ok
);
    import tapc_pkg::*;

    cfg_t  cfg;
    item_t push_item;
    item_t head_item;
    logic  q_push;
    logic  q_not_full;
    logic  q_valid;
    logic  q_pop;

    tapc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tapc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .start_enable  (start_enable),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .user_override (user_override),
        .q_push        (q_push),
        .q_item        (push_item),
        .q_ready       (q_not_full)
    );

    tapc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .not_full  (q_not_full),
        .valid     (q_valid),
        .head      (head_item),
        .pop       (q_pop)
    );

    tapc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_valid      (q_valid),
        .q_item       (head_item),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .cmd_valid    (cmd_valid),
        .vel_x        (vel_x),
        .vel_y        (vel_y),
        .vel_z        (vel_z),
        .executing    (executing),
        .at_target    (at_target),
        .mission_done (mission_done),
        .mission_ok   (mission_ok)
    );

endmodule

`default_nettype wire
